// ===== sv/sm83f_pkg.sv =====
`default_nettype none

package sm83f_pkg;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CYC_W   = 5;
    localparam int unsigned PEND_W  = 3;
    localparam int unsigned FLAG_W  = 4;
    localparam int unsigned MAX_RES = 3;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

    localparam logic REQ_INSTR = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    localparam logic [PEND_W-1:0] PEND_NONE   = 3'd0;
    localparam logic [PEND_W-1:0] PEND_LDH    = 3'd1;
    localparam logic [PEND_W-1:0] PEND_POP_LO = 3'd2;
    localparam logic [PEND_W-1:0] PEND_POP_HI = 3'd3;
    localparam logic [PEND_W-1:0] PEND_LDC    = 3'd4;
    localparam logic [PEND_W-1:0] PEND_A16    = 3'd5;

    localparam logic [BYTE_W-1:0] OP_LOAD_HIGH  = 8'hF0;
    localparam logic [BYTE_W-1:0] OP_POP_ACC    = 8'hF1;
    localparam logic [BYTE_W-1:0] OP_LD_A_C     = 8'hF2;
    localparam logic [BYTE_W-1:0] OP_DI         = 8'hF3;
    localparam logic [BYTE_W-1:0] OP_PUSH_ACC   = 8'hF5;
    localparam logic [BYTE_W-1:0] OP_OR_IMM     = 8'hF6;
    localparam logic [BYTE_W-1:0] OP_RESTART_30 = 8'hF7;
    localparam logic [BYTE_W-1:0] OP_LD_HL_SP   = 8'hF8;
    localparam logic [BYTE_W-1:0] OP_COPY_HL_SP = 8'hF9;
    localparam logic [BYTE_W-1:0] OP_LOAD_ABS   = 8'hFA;
    localparam logic [BYTE_W-1:0] OP_EI         = 8'hFB;
    localparam logic [BYTE_W-1:0] OP_CMP_IMM    = 8'hFE;
    localparam logic [BYTE_W-1:0] OP_RESTART_38 = 8'hFF;

    localparam logic [3:0] ROW_F = 4'hF;

    localparam logic [BYTE_W-1:0] HIGH_PAGE = 8'hFF;
    localparam logic [ADDR_W-1:0] RST_30_VEC = 16'h0030;
    localparam logic [ADDR_W-1:0] RST_38_VEC = 16'h0038;

    localparam logic [CYC_W-1:0] CYC_4  = 5'd4;
    localparam logic [CYC_W-1:0] CYC_8  = 5'd8;
    localparam logic [CYC_W-1:0] CYC_12 = 5'd12;
    localparam logic [CYC_W-1:0] CYC_16 = 5'd16;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] write_data;
        logic [CYC_W-1:0]  cycle_count;
    } t_result;

    localparam t_result RES_BAD = '{kind: KIND_BAD, address: '0, write_data: '0,
                                    cycle_count: '0};

endpackage

`default_nettype wire

// ===== sv/sm83f_if.sv =====
`default_nettype none

interface sm83f_req_if import sm83f_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [BYTE_W-1:0] opcode;
    logic [BYTE_W-1:0] imm_lo;
    logic [BYTE_W-1:0] imm_hi;
    logic [BYTE_W-1:0] reg_c_value;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, req_type, opcode, imm_lo, imm_hi, reg_c_value, read_data,
                    input ready);
    modport sink (input valid, req_type, opcode, imm_lo, imm_hi, reg_c_value, read_data,
                  output ready);
endinterface

interface sm83f_res_if import sm83f_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] write_data;
    logic              is_last;
    logic [CYC_W-1:0]  cycle_count;
    logic [BYTE_W-1:0] acc_out;
    logic [BYTE_W-1:0] flags_out;
    logic [ADDR_W-1:0] hl_out;
    logic [ADDR_W-1:0] sp_out;
    logic [ADDR_W-1:0] pc_out;
    logic              ime_out;

    modport source (output valid, kind, address, write_data, is_last, cycle_count, acc_out,
                    flags_out, hl_out, sp_out, pc_out, ime_out,
                    input ready);
    modport sink (input valid, kind, address, write_data, is_last, cycle_count, acc_out,
                  flags_out, hl_out, sp_out, pc_out, ime_out,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/sm83_opcode_row_f_execute.sv =====
`default_nettype none

// Executes opcodes 0xF0 to 0xFF of an SM83 core, holding A, F, HL, SP, PC and IME here.
// Each request is decoded and applied to the registers in the cycle it is taken, and its
// one to three results (read request, writes, completion or illegal) are queued in a small
// result register and presented one per cycle while the receiver is ready; the register
// values shown alongside every result are those after the whole request. A request
// producing one result can be taken every cycle, even while the previous result is still
// waiting to be taken, as long as that result leaves in the same cycle; PUSH AF and RST
// queue three results, so the next request is taken at the earliest in the cycle in which
// their completion result leaves. Reads are answered by a later read-data request; POP AF
// needs two such round trips.

module sm83_opcode_row_f_execute import sm83f_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sm83f_req_if.sink   i_req,
    sm83f_res_if.source o_res
);

    logic [BYTE_W-1:0] r_acc, n_acc;
    logic [FLAG_W-1:0] r_flag, n_flag;
    logic [BYTE_W-1:0] r_h, n_h;
    logic [BYTE_W-1:0] r_l, n_l;
    logic [ADDR_W-1:0] r_sp, n_sp;
    logic [ADDR_W-1:0] r_pc, n_pc;
    logic              r_ime, n_ime;
    logic [PEND_W-1:0] r_pend, n_pend;

    t_result           r_res [MAX_RES];
    t_result           n_res [MAX_RES];
    logic [1:0]        r_left, n_cnt;

    logic              take;
    logic              pop;
    logic [ADDR_W-1:0] pc1, pc2, pc3, sp1, sp2, sp_sum, sp_inc;
    logic [4:0]        half_sum;
    logic [8:0]        byte_sum;

    assign pop  = (r_left != 2'd0) && o_res.ready;
    assign i_req.ready = (r_left == 2'd0) || ((r_left == 2'd1) && o_res.ready);
    assign take = i_req.valid && i_req.ready;

    assign pc1      = r_pc + 16'd1;
    assign pc2      = r_pc + 16'd2;
    assign pc3      = r_pc + 16'd3;
    assign sp1      = r_sp - 16'd1;
    assign sp2      = r_sp - 16'd2;
    assign sp_inc   = r_sp + 16'd1;
    assign sp_sum   = r_sp + {{8{i_req.imm_lo[7]}}, i_req.imm_lo};
    assign half_sum = {1'b0, r_sp[3:0]} + {1'b0, i_req.imm_lo[3:0]};
    assign byte_sum = {1'b0, r_sp[7:0]} + {1'b0, i_req.imm_lo};

    always_comb begin
        n_acc  = r_acc;
        n_flag = r_flag;
        n_h    = r_h;
        n_l    = r_l;
        n_sp   = r_sp;
        n_pc   = r_pc;
        n_ime  = r_ime;
        n_pend = r_pend;
        n_cnt  = 2'd1;
        n_res[0] = RES_BAD;
        n_res[1] = RES_BAD;
        n_res[2] = RES_BAD;

        if (i_req.req_type == REQ_INSTR) begin
            if ((r_pend == PEND_NONE) && (i_req.opcode[7:4] == ROW_F)) begin
                case (i_req.opcode)
                    OP_LOAD_HIGH: begin
                        n_pc   = pc2;
                        n_pend = PEND_LDH;
                        n_res[0] = '{KIND_READ, {HIGH_PAGE, i_req.imm_lo}, '0, '0};
                    end
                    OP_POP_ACC: begin
                        n_pc   = pc1;
                        n_pend = PEND_POP_LO;
                        n_res[0] = '{KIND_READ, r_sp, '0, '0};
                    end
                    OP_LD_A_C: begin
                        n_pc   = pc1;
                        n_pend = PEND_LDC;
                        n_res[0] = '{KIND_READ, {HIGH_PAGE, i_req.reg_c_value}, '0, '0};
                    end
                    OP_DI: begin
                        n_pc  = pc1;
                        n_ime = 1'b0;
                        n_res[0] = '{KIND_DONE, '0, '0, CYC_4};
                    end
                    OP_EI: begin
                        n_pc  = pc1;
                        n_ime = 1'b1;
                        n_res[0] = '{KIND_DONE, '0, '0, CYC_4};
                    end
                    OP_PUSH_ACC: begin
                        n_pc  = pc1;
                        n_sp  = sp2;
                        n_cnt = 2'd3;
                        n_res[0] = '{KIND_WRITE, sp1, r_acc, '0};
                        n_res[1] = '{KIND_WRITE, sp2, {r_flag, 4'h0}, '0};
                        n_res[2] = '{KIND_DONE, '0, '0, CYC_16};
                    end
                    OP_RESTART_30, OP_RESTART_38: begin
                        n_pc  = (i_req.opcode == OP_RESTART_30) ? RST_30_VEC : RST_38_VEC;
                        n_sp  = sp2;
                        n_cnt = 2'd3;
                        n_res[0] = '{KIND_WRITE, sp1, pc1[15:8], '0};
                        n_res[1] = '{KIND_WRITE, sp2, pc1[7:0], '0};
                        n_res[2] = '{KIND_DONE, '0, '0, CYC_16};
                    end
                    OP_OR_IMM: begin
                        n_pc   = pc2;
                        n_acc  = r_acc | i_req.imm_lo;
                        n_flag = {((r_acc | i_req.imm_lo) == 8'h00), 3'b000};
                        n_res[0] = '{KIND_DONE, '0, '0, CYC_8};
                    end
                    OP_LD_HL_SP: begin
                        n_pc   = pc2;
                        n_h    = sp_sum[15:8];
                        n_l    = sp_sum[7:0];
                        n_flag = {2'b00, half_sum[4], byte_sum[8]};
                        n_res[0] = '{KIND_DONE, '0, '0, CYC_12};
                    end
                    OP_COPY_HL_SP: begin
                        n_pc = pc1;
                        n_sp = {r_h, r_l};
                        n_res[0] = '{KIND_DONE, '0, '0, CYC_8};
                    end
                    OP_LOAD_ABS: begin
                        n_pc   = pc3;
                        n_pend = PEND_A16;
                        n_res[0] = '{KIND_READ, {i_req.imm_hi, i_req.imm_lo}, '0, '0};
                    end
                    OP_CMP_IMM: begin
                        n_pc   = pc2;
                        n_flag = {(r_acc == i_req.imm_lo), 1'b1,
                                  (r_acc[3:0] < i_req.imm_lo[3:0]), (r_acc < i_req.imm_lo)};
                        n_res[0] = '{KIND_DONE, '0, '0, CYC_8};
                    end
                    default: begin
                        n_res[0] = RES_BAD;
                    end
                endcase
            end
        end else begin
            case (r_pend)
                PEND_LDH: begin
                    n_acc  = i_req.read_data;
                    n_pend = PEND_NONE;
                    n_res[0] = '{KIND_DONE, '0, '0, CYC_12};
                end
                PEND_POP_LO: begin
                    n_flag = i_req.read_data[7:4];
                    n_sp   = sp_inc;
                    n_pend = PEND_POP_HI;
                    n_res[0] = '{KIND_READ, sp_inc, '0, '0};
                end
                PEND_POP_HI: begin
                    n_acc  = i_req.read_data;
                    n_sp   = sp_inc;
                    n_pend = PEND_NONE;
                    n_res[0] = '{KIND_DONE, '0, '0, CYC_12};
                end
                PEND_LDC: begin
                    n_acc  = i_req.read_data;
                    n_pend = PEND_NONE;
                    n_res[0] = '{KIND_DONE, '0, '0, CYC_8};
                end
                PEND_A16: begin
                    n_acc  = i_req.read_data;
                    n_pend = PEND_NONE;
                    n_res[0] = '{KIND_DONE, '0, '0, CYC_16};
                end
                default: begin
                    n_res[0] = RES_BAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_flag <= '0;
            r_h    <= '0;
            r_l    <= '0;
            r_sp   <= '0;
            r_pc   <= '0;
            r_ime  <= 1'b0;
            r_pend <= PEND_NONE;
            r_left <= 2'd0;
        end else if (take) begin
            r_acc  <= n_acc;
            r_flag <= n_flag;
            r_h    <= n_h;
            r_l    <= n_l;
            r_sp   <= n_sp;
            r_pc   <= n_pc;
            r_ime  <= n_ime;
            r_pend <= n_pend;
            r_left <= n_cnt;
        end else if (pop) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res[0] <= n_res[0];
            r_res[1] <= n_res[1];
            r_res[2] <= n_res[2];
        end else if (pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    assign o_res.valid       = (r_left != 2'd0);
    assign o_res.kind        = r_res[0].kind;
    assign o_res.address     = r_res[0].address;
    assign o_res.write_data  = r_res[0].write_data;
    assign o_res.cycle_count = r_res[0].cycle_count;
    assign o_res.is_last     = (r_left == 2'd1);
    assign o_res.acc_out     = r_acc;
    assign o_res.flags_out   = {r_flag, 4'h0};
    assign o_res.hl_out      = {r_h, r_l};
    assign o_res.sp_out      = r_sp;
    assign o_res.pc_out      = r_pc;
    assign o_res.ime_out     = r_ime;

endmodule

`default_nettype wire

// ===== sv/sm83f_checker.sv =====
`default_nettype none

module sm83f_checker import sm83f_pkg::*; (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_res_valid,
    input wire              i_res_ready,
    input wire [KIND_W-1:0] i_res_kind,
    input wire [ADDR_W-1:0] i_res_address,
    input wire              i_res_is_last,
    input wire [CYC_W-1:0]  i_res_cycle_count
);

    // A result that is held back must stay in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_kind)
            && $stable(i_res_address) && $stable(i_res_is_last))
        else $error("held result changed");

    // Only stack writes are ever followed by further results of the same request.
    a_only_writes_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_is_last |-> i_res_kind == KIND_WRITE)
        else $error("non-final result is not a write");

    // A completion always closes its request.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_kind == KIND_DONE) |-> i_res_is_last)
        else $error("completion is not the final result");

    // Cycles are charged on completions only, and never zero there.
    a_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> ((i_res_kind == KIND_DONE) == (i_res_cycle_count != '0)))
        else $error("cycle count does not match result kind");

endmodule

bind sm83_opcode_row_f_execute sm83f_checker u_sm83f_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_kind        (o_res.kind),
    .i_res_address     (o_res.address),
    .i_res_is_last     (o_res.is_last),
    .i_res_cycle_count (o_res.cycle_count)
);

`default_nettype wire
